// ===== design/sot_pkg.sv =====
// shared types and constants for the sphere overlap table
// no dependencies
package sot_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int NUM_CELLS   = 4;
  localparam int CELL_W      = $clog2(NUM_CELLS);
  localparam int CELL_DEPTH  = TABLE_DEPTH / NUM_CELLS;
  localparam int ROW_W       = $clog2(CELL_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COORD_W     = 16;
  localparam int RAD_W       = 15;
  localparam int ENTRY_W     = 3 * COORD_W + RAD_W;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 16;

  typedef enum logic {
    OP_QUERY  = 1'b0,
    OP_INSERT = 1'b1
  } opcode_e;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic        [RAD_W-1:0]   r;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } sphere_t;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] addr;
    logic             hit;
  } token_t;

  typedef struct packed {
    logic              we;
    logic [CELL_W-1:0] bank;
    logic [ROW_W-1:0]  row;
    sphere_t           entry;
  } wr_t;

  typedef struct packed {
    logic [CNT_W-1:0] stored_count;
    status_e          status;
    logic             overlap_found;
  } result_t;

endpackage

// ===== design/sphere_overlap_table_unit.sv =====
// top level of the sphere overlap table: item control and the cell chain
// depends on sot_pkg and sot_cell
//
// channel  dir  bus            fields (lowest bit first)
// s_axis   in   tdata[63:0]    center_x, center_y, center_z, radius
//               tuser[0]       opcode
// m_axis   out  tdata[15:0]    overlap_found, status, stored_count
//
// a query scans the stored entries: four cells each read one entry of their bank
// per cycle, and the chain is 16 stages deep
// reset clears the entry count and the control state; the table banks are not cleared
// a stalled result sits in the output register while the next item is taken
module sphere_overlap_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // center_x, center_y, center_z, radius
  input  logic [0:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // overlap_found, status, stored_count
);
  import sot_pkg::*;

  state_e          state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  sphere_t         query_q, query_d;
  logic [ROW_W:0]  rows_q, rows_d, issue_q, issue_d, ret_q, ret_d;
  logic            hit_q, hit_d;
  result_t         res_q, res_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;

  logic            accept;
  opcode_e         in_op;
  sphere_t         in_sph;
  logic [CNT_W:0]  cnt_rnd;
  wr_t             wr;
  token_t          tok_head;
  token_t          tok [NUM_CELLS+1];

  assign in_op   = opcode_e'(s_axis_tuser[0]);
  assign in_sph  = sphere_t'(s_axis_tdata[ENTRY_W-1:0]);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign cnt_rnd = {1'b0, count_q} + (CNT_W+1)'(NUM_CELLS - 1);
  assign tok[0]  = tok_head;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    query_d     = query_q;
    rows_d      = rows_q;
    issue_d     = issue_q;
    ret_d       = ret_q;
    hit_d       = hit_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    wr          = '0;
    tok_head    = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (tok[NUM_CELLS].valid) begin
      ret_d = ret_q + 1'b1;
      hit_d = hit_q | tok[NUM_CELLS].hit;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_INSERT) begin
            if (count_q < CNT_W'(TABLE_DEPTH)) begin
              wr.we    = 1'b1;
              wr.bank  = count_q[CELL_W-1:0];
              wr.row   = count_q[CELL_W +: ROW_W];
              wr.entry = in_sph;
              count_d  = count_q + 1'b1;
              res_d    = '{stored_count: count_q + 1'b1, status: STATUS_OK,
                           overlap_found: 1'b0};
            end else begin
              res_d    = '{stored_count: count_q, status: STATUS_FULL,
                           overlap_found: 1'b0};
            end
            state_d = ST_RESP;
          end else begin
            query_d = in_sph;
            if (count_q == '0) begin
              res_d   = '{stored_count: count_q, status: STATUS_OK, overlap_found: 1'b0};
              state_d = ST_RESP;
            end else begin
              rows_d  = cnt_rnd[CELL_W +: ROW_W+1];
              issue_d = '0;
              ret_d   = '0;
              hit_d   = 1'b0;
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        tok_head = '{valid: 1'b1, addr: issue_q[ROW_W-1:0], hit: 1'b0};
        issue_d  = issue_q + 1'b1;
        if (issue_q + 1'b1 == rows_q) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (ret_q == rows_q) begin
          res_d   = '{stored_count: count_q, status: STATUS_OK, overlap_found: hit_q};
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    sot_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CELL_W'(k)),
      .count_i    (count_q),
      .query_i    (query_q),
      .wr_i       (wr),
      .tok_i      (tok[k]),
      .tok_o      (tok[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rows_q      <= '0;
      issue_q     <= '0;
      ret_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rows_q      <= rows_d;
      issue_q     <= issue_d;
      ret_q       <= ret_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q <= query_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), out_q};

endmodule

// ===== design/sot_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module sot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sot_cell.sv =====
// one cell of the compare chain: a bank of the table and a compare pipeline
// depends on sot_pkg and sot_ram
module sot_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [sot_pkg::CELL_W-1:0] cell_idx_i,
  input  logic [sot_pkg::CNT_W-1:0]  count_i,
  input  sot_pkg::sphere_t          query_i,
  input  sot_pkg::wr_t              wr_i,
  input  sot_pkg::token_t           tok_i,
  output sot_pkg::token_t           tok_o
);
  import sot_pkg::*;

  logic    [ENTRY_W-1:0] rdata;
  sphere_t               ent;

  token_t tok1_q, tok2_q, tok3_q, tok4_q;

  logic signed [COORD_W:0] dx_d, dy_d, dz_d, dx_q, dy_q, dz_q;
  logic        [RAD_W:0]   rs_d, rs_q;
  logic                    ok_d, ok2_q, ok3_q;
  logic signed [2*COORD_W+1:0] px, py, pz;
  logic [SQ_W-1:0]   sqx_q, sqy_q, sqz_q, rs2_q;
  logic [SQ_W+1:0]   d2;
  logic              hit;
  logic [CELL_W+ROW_W-1:0] idx;

  sot_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CELL_DEPTH)
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (wr_i.we && (wr_i.bank == cell_idx_i)),
    .waddr_i (wr_i.row),
    .wdata_i (wr_i.entry),
    .re_i    (tok_i.valid),
    .raddr_i (tok_i.addr),
    .rdata_o (rdata)
  );

  assign ent = sphere_t'(rdata);

  // stage 1: differences, radius sum, entry in use
  assign idx  = {tok1_q.addr, cell_idx_i};
  assign ok_d = CNT_W'(idx) < count_i;
  assign dx_d = $signed({query_i.x[COORD_W-1], query_i.x}) - $signed({ent.x[COORD_W-1], ent.x});
  assign dy_d = $signed({query_i.y[COORD_W-1], query_i.y}) - $signed({ent.y[COORD_W-1], ent.y});
  assign dz_d = $signed({query_i.z[COORD_W-1], query_i.z}) - $signed({ent.z[COORD_W-1], ent.z});
  assign rs_d = {1'b0, query_i.r} + {1'b0, ent.r};

  // stage 2: squares
  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;
  assign pz = dz_q * dz_q;

  // stage 3: distance sum and compare
  assign d2  = (SQ_W+2)'(sqx_q) + (SQ_W+2)'(sqy_q) + (SQ_W+2)'(sqz_q);
  assign hit = ok3_q && (d2 < {2'b00, rs2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok1_q <= '0;
      tok2_q <= '0;
      tok3_q <= '0;
      tok4_q <= '0;
    end else begin
      tok1_q <= tok_i;
      tok2_q <= tok1_q;
      tok3_q <= tok2_q;
      tok4_q <= '{valid: tok3_q.valid, addr: tok3_q.addr, hit: tok3_q.hit | hit};
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    dz_q  <= dz_d;
    rs_q  <= rs_d;
    ok2_q <= ok_d;
    sqx_q <= px[SQ_W-1:0];
    sqy_q <= py[SQ_W-1:0];
    sqz_q <= pz[SQ_W-1:0];
    rs2_q <= SQ_W'(rs_q) * SQ_W'(rs_q);
    ok3_q <= ok2_q;
  end

  assign tok_o = tok4_q;

endmodule

// ===== design/sot_checker.sv =====
// port-level checks for the sphere overlap table
// depends on sot_pkg; bound to sphere_overlap_table_unit
module sot_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import sot_pkg::*;

  logic [CNT_W-1:0] cnt;
  assign cnt = m_axis_tdata[CNT_W+1:2];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("overlap and refusal in one item");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt <= CNT_W'(TABLE_DEPTH))
    else $error("stored count beyond table depth");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> cnt == CNT_W'(TABLE_DEPTH))
    else $error("insert refused while table not full");

endmodule

bind sphere_overlap_table_unit sot_checker u_sot_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
